### sv/pmks_pkg.sv
// ----------------------------------------------------------------------------
// pmks_pkg
// Types, constants and helper functions shared by the k-mer scan modules.
// ----------------------------------------------------------------------------
package pmks_pkg;

   localparam int KMER_MAX    = 16;
   localparam int SEQ_MAX     = 4096;

   localparam int KMER_W      = $clog2(KMER_MAX + 1);
   localparam int COL_IDX_W   = (KMER_MAX > 1) ? $clog2(KMER_MAX) : 1;
   localparam int PROF_DEPTH  = 4 * KMER_MAX;
   localparam int PROF_ADDR_W = $clog2(PROF_DEPTH);
   localparam int SEQ_CNT_W   = $clog2(SEQ_MAX + 1);

   localparam int KLEN_W      = 5;
   localparam int WEIGHT_W    = 8;
   localparam int CHAR_W      = 8;
   localparam int POS_W       = 12;
   localparam int SCORE_W     = 64;
   localparam int CODE_W      = 3;
   localparam int WIDE_W      = SCORE_W + WEIGHT_W;

   localparam logic [KLEN_W-1:0] KMER_RESET = 5'd15;

   localparam logic [CHAR_W-1:0] ASCII_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_C = 8'h43;
   localparam logic [CHAR_W-1:0] ASCII_G = 8'h47;
   localparam logic [CHAR_W-1:0] ASCII_T = 8'h54;

   localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
   localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
   localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
   localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

   localparam logic CMD_WRITE_WEIGHT = 1'b0;
   localparam logic CMD_SEQ_CHAR     = 1'b1;

   typedef struct packed {
      logic                command;
      logic [1:0]          nucleotide;
      logic [3:0]          column;
      logic [WEIGHT_W-1:0] weight;
      logic [CHAR_W-1:0]   base_char;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]   best_position;
      logic [SCORE_W-1:0] best_score;
      logic               short_sequence;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RUN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic write_entry;
      logic accept_char;
      logic start_product;
      logic step;
      logic update_best;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic window_ready;
      logic product_done;
      logic rsp_free;
      logic last_char;
   } ctrl_status_type;

   function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] ch);
      logic [CODE_W-1:0] code;
      case (ch)
         ASCII_A: code = CODE_A;
         ASCII_C: code = CODE_C;
         ASCII_G: code = CODE_G;
         ASCII_T: code = CODE_T;
         default: code = CODE_OTHER;
      endcase
      return code;
   endfunction

   function automatic logic [KMER_W-1:0] effective_k(input logic [KLEN_W-1:0] k);
      logic [KMER_W-1:0] keff;
      if (k == '0) begin
         keff = KMER_W'(1);
      end else if (int'(k) > KMER_MAX) begin
         keff = KMER_W'(KMER_MAX);
      end else begin
         keff = KMER_W'(k);
      end
      return keff;
   endfunction

endpackage

### sv/pmks_ram.sv
// ----------------------------------------------------------------------------
// pmks_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pmks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pmks_ctrl.sv
// ----------------------------------------------------------------------------
// pmks_ctrl
// Sequencer for the k-mer scan: takes requests, runs the per-column product
// loop and hands the result to the output register.
// ----------------------------------------------------------------------------
module pmks_ctrl
   import pmks_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_command,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_command == CMD_SEQ_CHAR)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.window_ready ? ST_RUN : ST_FINISH;
         end
         ST_RUN: begin
            if (status.product_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // a closing character waits here while the previous result is unread
            if (!status.last_char || status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      cmd               = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.write_entry = req_valid && (req_command == CMD_WRITE_WEIGHT);
            cmd.accept_char = req_valid && (req_command == CMD_SEQ_CHAR);
         end
         ST_CHECK: begin
            cmd.start_product = status.window_ready;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update_best = 1'b1;
         end
         ST_FINISH: begin
            cmd.emit = status.last_char && status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/pmks_datapath.sv
// ----------------------------------------------------------------------------
// pmks_datapath
// Profile store, character window, product accumulator with saturation,
// best-window tracking and the result register.
// ----------------------------------------------------------------------------
module pmks_datapath
   import pmks_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [KLEN_W-1:0]  csr_write_data,
   input  req_type            req_data,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   logic [KLEN_W-1:0]    kmer_len_ff,     kmer_len_in;
   logic [CODE_W-1:0]    window_ff [KMER_MAX];
   logic [CODE_W-1:0]    window_in [KMER_MAX];
   logic [SEQ_CNT_W-1:0] chars_seen_ff,   chars_seen_in;
   logic                 entered_ff,      entered_in;
   logic                 last_ff,         last_in;
   logic [SCORE_W-1:0]   best_product_ff, best_product_in;
   logic [POS_W-1:0]     best_start_ff,   best_start_in;
   logic [KMER_W-1:0]    col_ff,          col_in;
   logic                 pipe_valid_ff,   pipe_valid_in;
   logic                 pipe_other_ff,   pipe_other_in;
   logic [SCORE_W-1:0]   prod_ff,         prod_in;
   logic                 sat_ff,          sat_in;
   logic                 zero_ff,         zero_in;
   logic                 rsp_valid_ff,    rsp_valid_in;
   rsp_type              rsp_data_ff,     rsp_data_in;

   logic [KMER_W-1:0]      keff;
   logic                   window_full;
   logic                   col_active;
   logic [KMER_W-1:0]      win_idx_wide;
   logic [CODE_W-1:0]      rd_code;
   logic [PROF_ADDR_W-1:0] rd_addr;
   logic                   rd_en;
   logic [PROF_ADDR_W-1:0] wr_addr;
   logic                   wr_en;
   logic [WEIGHT_W-1:0]    rd_weight;
   logic [WIDE_W-1:0]      mul;
   logic [SCORE_W-1:0]     score_now;

   assign keff        = effective_k(kmer_len_ff);
   assign window_full = int'(chars_seen_ff) >= int'(keff);
   assign col_active  = col_ff < keff;

   // column j of the window sits at KMER_MAX - k + j
   assign win_idx_wide = KMER_W'(KMER_MAX) - keff + col_ff;
   assign rd_code      = window_ff[win_idx_wide[COL_IDX_W-1:0]];
   assign rd_addr      = PROF_ADDR_W'(int'(rd_code[1:0]) * KMER_MAX
                                      + int'(col_ff[COL_IDX_W-1:0]));
   assign rd_en        = cmd.step && col_active && (rd_code != CODE_OTHER);

   assign wr_addr = PROF_ADDR_W'(int'(req_data.nucleotide) * KMER_MAX
                                 + int'(req_data.column));
   assign wr_en   = cmd.write_entry && (int'(req_data.column) < KMER_MAX);

   pmks_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (PROF_DEPTH)
   ) u_profile_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.weight),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_weight)
   );

   assign mul       = WIDE_W'(prod_ff) * WIDE_W'(rd_weight);
   assign score_now = zero_ff ? '0 : (sat_ff ? '1 : prod_ff);

   always_comb begin
      kmer_len_in     = kmer_len_ff;
      window_in       = window_ff;
      chars_seen_in   = chars_seen_ff;
      entered_in      = entered_ff;
      last_in         = last_ff;
      best_product_in = best_product_ff;
      best_start_in   = best_start_ff;
      col_in          = col_ff;
      pipe_valid_in   = pipe_valid_ff;
      pipe_other_in   = pipe_other_ff;
      prod_in         = prod_ff;
      sat_in          = sat_ff;
      zero_in         = zero_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (csr_write_enable) begin
         kmer_len_in = csr_write_data;
      end

      if (cmd.accept_char) begin
         last_in = req_data.last;
         if (int'(chars_seen_ff) < SEQ_MAX) begin
            for (int i = 0; i < KMER_MAX - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[KMER_MAX - 1] = base_code(req_data.base_char);
            chars_seen_in = chars_seen_ff + 1'b1;
            entered_in    = 1'b1;
         end else begin
            entered_in = 1'b0;
         end
      end

      if (cmd.start_product) begin
         prod_in       = SCORE_W'(1);
         sat_in        = 1'b0;
         zero_in       = 1'b0;
         col_in        = '0;
         pipe_valid_in = 1'b0;
      end

      if (cmd.step) begin
         pipe_valid_in = col_active;
         pipe_other_in = rd_code == CODE_OTHER;
         if (col_active) begin
            col_in = col_ff + 1'b1;
         end
         // fold in the weight read on the previous cycle
         if (pipe_valid_ff && !pipe_other_ff) begin
            if (rd_weight == '0) begin
               zero_in = 1'b1;
            end else if (!sat_ff) begin
               if (|mul[WIDE_W-1:SCORE_W]) begin
                  sat_in = 1'b1;
               end else begin
                  prod_in = mul[SCORE_W-1:0];
               end
            end
         end
      end

      if (cmd.update_best) begin
         if (score_now >= best_product_ff) begin
            best_product_in = score_now;
            best_start_in   = POS_W'(chars_seen_ff - SEQ_CNT_W'(keff));
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (window_full) begin
            rsp_data_in.best_position  = best_start_ff;
            rsp_data_in.best_score     = best_product_ff;
            rsp_data_in.short_sequence = 1'b0;
         end else begin
            rsp_data_in.best_position  = '0;
            rsp_data_in.best_score     = '0;
            rsp_data_in.short_sequence = 1'b1;
         end
         // start a fresh sequence, the profile stays
         for (int i = 0; i < KMER_MAX; i++) begin
            window_in[i] = '0;
         end
         chars_seen_in   = '0;
         best_product_in = '0;
         best_start_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff     <= KMER_RESET;
         for (int i = 0; i < KMER_MAX; i++) begin
            window_ff[i] <= '0;
         end
         chars_seen_ff   <= '0;
         entered_ff      <= 1'b0;
         last_ff         <= 1'b0;
         best_product_ff <= '0;
         best_start_ff   <= '0;
         col_ff          <= '0;
         pipe_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         kmer_len_ff     <= kmer_len_in;
         window_ff       <= window_in;
         chars_seen_ff   <= chars_seen_in;
         entered_ff      <= entered_in;
         last_ff         <= last_in;
         best_product_ff <= best_product_in;
         best_start_ff   <= best_start_in;
         col_ff          <= col_in;
         pipe_valid_ff   <= pipe_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_other_ff <= pipe_other_in;
      prod_ff       <= prod_in;
      sat_ff        <= sat_in;
      zero_ff       <= zero_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign status.window_ready = entered_ff && window_full;
   assign status.product_done = (col_ff == keff) && !pipe_valid_ff;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;
   assign status.last_char    = last_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/profile_most_probable_kmer_scan.sv
// ----------------------------------------------------------------------------
// profile_most_probable_kmer_scan
// Finds the most probable k-mer of a DNA sequence under a 4-by-k weight profile.
// ----------------------------------------------------------------------------
// Usage:
//   csr_write_enable/csr_write_data set k (0 acts as 1, above 16 acts as 16);
//   write it only while the block is idle. Reset value is 15.
//   req_*: a request with command 0 writes one profile weight, command 1
//   presents one ASCII sequence character; last marks the end of a sequence.
//   rsp_*: one response per closing character: start of the best window (the
//   later one on a tie), its product saturated at all ones, or short_sequence
//   set when no full window was seen.
// Timing:
//   a weight write is taken while idle. A character passes the check and
//   finish states, with run and update between them when it completes a
//   window: the product walks the k columns through the single read port of
//   the profile RAM, one column per cycle, with one 64x8 multiply per column.
// Reset clears the window, the counters and the best score; profile entries
// hold nothing until written. A finished response sits in an output register;
// further requests are taken while it waits, and only a closing character
// stalls until the previous response has been taken.
// ----------------------------------------------------------------------------
module profile_most_probable_kmer_scan
   import pmks_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [KLEN_W-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   pmks_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .status      (ctrl_status),
      .cmd         (ctrl_cmd)
   );

   pmks_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (ctrl_cmd),
      .status           (ctrl_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

   a_short_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.short_sequence |->
         (rsp_data.best_score == '0) && (rsp_data.best_position == '0))
      else $error("short sequence response carries a score or position");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.write_entry, ctrl_cmd.accept_char, ctrl_cmd.start_product,
                ctrl_cmd.step, ctrl_cmd.update_best, ctrl_cmd.emit}))
      else $error("more than one datapath command in a cycle");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.emit |=> rsp_valid)
      else $error("emitted response not presented");

endmodule
